FILE: hw/rtl/u8250_pkg.sv
// ----------------------------------------------------------------------------
// u8250_pkg
// Operation codes, register offsets and fixed values of the 8250 register block.
// ----------------------------------------------------------------------------
package u8250_pkg;

  // operation codes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  // register offsets
  localparam logic [2:0] ADDR_DATA = 3'd0;
  localparam logic [2:0] ADDR_IER  = 3'd1;
  localparam logic [2:0] ADDR_IIR  = 3'd2;
  localparam logic [2:0] ADDR_LCR  = 3'd3;
  localparam logic [2:0] ADDR_MCR  = 3'd4;
  localparam logic [2:0] ADDR_LSR  = 3'd5;
  localparam logic [2:0] ADDR_MSR  = 3'd6;

  // fixed register values and bit positions
  localparam logic [7:0] LSR_BASE  = 8'h60;
  localparam logic [7:0] MSR_VALUE = 8'hb0;
  localparam int unsigned DLAB_BIT  = 7;
  localparam int unsigned INTR_THRE = 1;

  // interrupt numbers
  localparam logic INTR_RX   = 1'b0;
  localparam logic INTR_THR  = 1'b1;

endpackage

FILE: hw/rtl/uart_8250_register_model.sv
// ----------------------------------------------------------------------------
// uart_8250_register_model
// Register file of a plain 8250 UART: bus reads and writes, receive-ready
// polling and interrupt prioritization, one operation per word.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, operation, address,          | into block
//          | write_data, rx_available, rx_data                |
//  out     | out_valid, out_stall, read_data, tx_valid,       | out of block
//          | tx_data, rx_consume, irq_pending                 |
//
// The register state and the result register are updated at the edge that
// accepts the word, so one word can enter per cycle while in_stall is low.
// The result appears in the cycle after acceptance and holds while out_stall is
// high; in_stall is high only while a result waits and out_stall is high.
// Synchronous reset clears all UART registers and the result valid flag.
// ----------------------------------------------------------------------------
module uart_8250_register_model (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [2:0] address,
  input  logic [7:0] write_data,
  input  logic       rx_available,
  input  logic [7:0] rx_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_data,
  output logic       rx_consume,
  output logic       irq_pending
);
  import u8250_pkg::*;

  // architectural registers
  logic [7:0] line_control;
  logic [7:0] modem_control;
  logic [7:0] interrupt_enable;
  logic [7:0] divisor_low;
  logic [7:0] divisor_high;
  logic [1:0] pending_interrupts;
  logic       current_interrupt;
  logic       receive_ready;

  logic [7:0] line_control_next;
  logic [7:0] modem_control_next;
  logic [7:0] interrupt_enable_next;
  logic [7:0] divisor_low_next;
  logic [7:0] divisor_high_next;
  logic [1:0] pending_interrupts_next;
  logic       current_interrupt_next;
  logic       receive_ready_next;

  logic [7:0] read_data_next;
  logic       tx_valid_next;
  logic [7:0] tx_data_next;
  logic       rx_consume_next;

  logic       accept;
  logic       dlab;
  logic       ready_polled;
  logic [1:0] pending_masked;

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign dlab           = line_control[DLAB_BIT];
  assign ready_polled   = receive_ready | rx_available;
  assign pending_masked = {pending_interrupts[1], receive_ready} & interrupt_enable[1:0];

  // next state and result for the word on the input
  always_comb begin
    line_control_next       = line_control;
    modem_control_next      = modem_control;
    interrupt_enable_next   = interrupt_enable;
    divisor_low_next        = divisor_low;
    divisor_high_next       = divisor_high;
    pending_interrupts_next = pending_interrupts;
    current_interrupt_next  = current_interrupt;
    receive_ready_next      = receive_ready;
    read_data_next          = 8'h00;
    tx_valid_next           = 1'b0;
    tx_data_next            = 8'h00;
    rx_consume_next         = 1'b0;

    unique case (operation)
      OP_READ: begin
        case (address)
          ADDR_DATA: begin
            if (dlab) begin
              read_data_next = divisor_low;
            end else if (ready_polled) begin
              read_data_next     = rx_data;
              rx_consume_next    = 1'b1;
              receive_ready_next = 1'b0;
            end
          end
          ADDR_IER: read_data_next = dlab ? divisor_high : interrupt_enable;
          ADDR_IIR: begin
            read_data_next = {6'd0, current_interrupt, ~|pending_interrupts};
            // reading IIR acknowledges a current THRE interrupt
            if (current_interrupt == INTR_THR) begin
              pending_interrupts_next[INTR_THRE] = 1'b0;
            end
          end
          ADDR_LCR: read_data_next = line_control;
          ADDR_MCR: read_data_next = modem_control;
          ADDR_LSR: read_data_next = LSR_BASE | {7'd0, receive_ready};
          ADDR_MSR: read_data_next = MSR_VALUE;
          default:  read_data_next = 8'h00;
        endcase
      end
      OP_WRITE: begin
        case (address)
          ADDR_DATA: begin
            if (dlab) begin
              divisor_low_next = write_data;
            end else begin
              tx_valid_next = 1'b1;
              tx_data_next  = write_data;
              pending_interrupts_next[INTR_THRE] = 1'b1;
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              divisor_high_next = write_data;
            end else begin
              interrupt_enable_next = write_data;
            end
          end
          ADDR_LCR: line_control_next  = write_data;
          ADDR_MCR: modem_control_next = write_data;
          default:  ;
        endcase
      end
      OP_POLL: begin
        receive_ready_next = ready_polled;
      end
      OP_UPDATE: begin
        // level receive interrupt, masked, highest pending bit wins
        pending_interrupts_next = pending_masked;
        if (|pending_masked) begin
          current_interrupt_next = pending_masked[1];
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_control       <= 8'h00;
      modem_control      <= 8'h00;
      interrupt_enable   <= 8'h00;
      divisor_low        <= 8'h00;
      divisor_high       <= 8'h00;
      pending_interrupts <= 2'b00;
      current_interrupt  <= 1'b0;
      receive_ready      <= 1'b0;
    end else if (accept) begin
      line_control       <= line_control_next;
      modem_control      <= modem_control_next;
      interrupt_enable   <= interrupt_enable_next;
      divisor_low        <= divisor_low_next;
      divisor_high       <= divisor_high_next;
      pending_interrupts <= pending_interrupts_next;
      current_interrupt  <= current_interrupt_next;
      receive_ready      <= receive_ready_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= read_data_next;
      tx_valid    <= tx_valid_next;
      tx_data     <= tx_data_next;
      rx_consume  <= rx_consume_next;
      irq_pending <= |(pending_interrupts_next & interrupt_enable_next[1:0]);
    end
  end

endmodule

FILE: tb/uart_8250_register_model_tb.sv
// ----------------------------------------------------------------------------
// uart_8250_register_model_tb
// Self-checking bench for the 8250 register block: a short directed table of
// reset values, divisor latch access, ignored offsets and the interrupt path,
// then random bus words in phases with random idle and stall bursts. Results
// are checked field by field against fixed rows or a cycle-free predictor.
// ----------------------------------------------------------------------------
module uart_8250_register_model_tb;
  import u8250_pkg::*;

  // offset with no register behind it
  localparam logic [2:0] ADDR_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic       rx_avail;
    logic [7:0] rx_byte;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       tx_v;
    logic [7:0] tx_byte;
    logic       consume;
    logic       irq;
  } bus_result_t;

  typedef struct {
    bus_word_t   word;
    bit          fixed;
    bus_result_t result;
  } plan_row_t;

  localparam bus_result_t QUIET = '0;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] operation;
  logic [2:0] address;
  logic [7:0] write_data;
  logic       rx_available;
  logic [7:0] rx_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic       rx_consume;
  logic       irq_pending;

  // typed expectation that travels with the word on the bus
  bit          word_fixed;
  bus_result_t word_fixed_result;

  bit send_gaps;
  bit sink_gaps;
  int mismatch_count;

  bus_result_t expected_results[$];
  plan_row_t   stim_plan[$];

  // predicted register state
  logic [7:0] line_ctrl    = '0;
  logic [7:0] modem_ctrl   = '0;
  logic [7:0] intr_enable  = '0;
  logic [7:0] div_latch_lo = '0;
  logic [7:0] div_latch_hi = '0;
  logic [1:0] intr_pend    = '0;
  logic       intr_cur     = '0;
  logic       rx_ready     = '0;

  uart_8250_register_model u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .address      (address),
    .write_data   (write_data),
    .rx_available (rx_available),
    .rx_data      (rx_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .tx_valid     (tx_valid),
    .tx_data      (tx_data),
    .rx_consume   (rx_consume),
    .irq_pending  (irq_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // advance the register state by one bus word and return its result
  function automatic bus_result_t predict_bus_cycle(bus_word_t w);
    bus_result_t r;
    logic        dlab;
    r    = '0;
    dlab = line_ctrl[DLAB_BIT];
    case (w.op)
      OP_READ: begin
        case (w.addr)
          ADDR_DATA: begin
            if (dlab) begin
              r.rd = div_latch_lo;
            end else begin
              if (w.rx_avail) rx_ready = 1'b1;
              if (rx_ready) begin
                r.rd      = w.rx_byte;
                r.consume = 1'b1;
                rx_ready  = 1'b0;
              end
            end
          end
          ADDR_IER: r.rd = dlab ? div_latch_hi : intr_enable;
          ADDR_IIR: begin
            r.rd = {6'd0, intr_cur, intr_pend == 2'b00};
            // reading the id acknowledges a current transmit interrupt
            if (intr_cur == INTR_THR) intr_pend[INTR_THRE] = 1'b0;
          end
          ADDR_LCR: r.rd = line_ctrl;
          ADDR_MCR: r.rd = modem_ctrl;
          ADDR_LSR: r.rd = LSR_BASE | {7'd0, rx_ready};
          ADDR_MSR: r.rd = MSR_VALUE;
          default:  r.rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (w.addr)
          ADDR_DATA: begin
            if (dlab) begin
              div_latch_lo = w.wdata;
            end else begin
              r.tx_v               = 1'b1;
              r.tx_byte            = w.wdata;
              intr_pend[INTR_THRE] = 1'b1;
            end
          end
          ADDR_IER: begin
            if (dlab) div_latch_hi = w.wdata;
            else intr_enable = w.wdata;
          end
          ADDR_LCR: line_ctrl = w.wdata;
          ADDR_MCR: modem_ctrl = w.wdata;
          default: ;
        endcase
      end
      OP_POLL: begin
        if (w.rx_avail) rx_ready = 1'b1;
      end
      default: begin
        // receive ready is a level source, then mask and pick the highest
        intr_pend[0] = rx_ready;
        intr_pend    = intr_pend & intr_enable[1:0];
        if (intr_pend != 2'b00) intr_cur = intr_pend[1];
      end
    endcase
    r.irq = |(intr_pend & intr_enable[1:0]);
    return r;
  endfunction

  task automatic flag_mismatch(string what, bus_result_t want, bus_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected rd=%h tx=%b/%h rx=%b irq=%b, got rd=%h tx=%b/%h rx=%b irq=%b",
               what, want.rd, want.tx_v, want.tx_byte, want.consume, want.irq,
               seen.rd, seen.tx_v, seen.tx_byte, seen.consume, seen.irq);
    end
  endtask

  // check results first, then record the word taken at this edge
  always @(posedge clk) begin
    bus_result_t seen;
    bus_result_t want;
    bus_result_t calc;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = {read_data, tx_valid, tx_data, rx_consume, irq_pending};
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected word", QUIET, seen);
        end else begin
          want = expected_results.pop_front();
          if (want.rd !== seen.rd || want.tx_v !== seen.tx_v ||
              want.tx_byte !== seen.tx_byte || want.consume !== seen.consume ||
              want.irq !== seen.irq) begin
            flag_mismatch("mismatch", want, seen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        calc = predict_bus_cycle({operation, address, write_data, rx_available, rx_data});
        expected_results.push_back(word_fixed ? word_fixed_result : calc);
      end
    end
  end

  // result side stalls in random bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic plan_word(logic [1:0] op, logic [2:0] addr, logic [7:0] wdata,
                           logic avail, logic [7:0] rxb, bit fixed,
                           bus_result_t res);
    plan_row_t row;
    row.word   = {op, addr, wdata, avail, rxb};
    row.fixed  = fixed;
    row.result = res;
    stim_plan.push_back(row);
  endtask

  // after an optional idle gap, present one word and hold it until the block takes it
  task automatic drive_word(bus_word_t w, bit fixed, bus_result_t res);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    operation         <= w.op;
    address           <= w.addr;
    write_data        <= w.wdata;
    rx_available      <= w.rx_avail;
    rx_data           <= w.rx_byte;
    word_fixed        <= fixed;
    word_fixed_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic bus_word_t random_bus_word();
    bus_word_t w;
    int        pick;
    pick       = $urandom_range(0, 99);
    w.op       = pick < 35 ? OP_READ : pick < 65 ? OP_WRITE : pick < 80 ? OP_POLL : OP_UPDATE;
    w.addr     = 3'($urandom_range(0, 7));
    w.wdata    = 8'($urandom_range(0, 255));
    w.rx_avail = 1'($urandom_range(0, 1));
    w.rx_byte  = 8'($urandom_range(0, 255));
    // keep the divisor latch closed most of the time so data traffic flows
    if (w.op == OP_WRITE && w.addr == ADDR_LCR && $urandom_range(0, 3) != 0) begin
      w.wdata[DLAB_BIT] = 1'b0;
    end
    return w;
  endfunction

  // stimulus and end of run
  initial begin
    int spin;
    rst               = 1'b1;
    in_valid          = 1'b0;
    operation         = OP_READ;
    address           = ADDR_DATA;
    write_data        = '0;
    rx_available      = 1'b0;
    rx_data           = '0;
    word_fixed        = 1'b0;
    word_fixed_result = QUIET;
    send_gaps         = 1'b0;
    sink_gaps         = 1'b0;
    mismatch_count    = 0;

    // reset values, fixed registers and the empty receiver
    plan_word(OP_READ,   ADDR_IER,    8'h00, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_READ,   ADDR_IIR,    8'h00, 1'b0, 8'h00, 1'b1,
              {8'h01, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_word(OP_READ,   ADDR_LSR,    8'h00, 1'b0, 8'h00, 1'b1,
              {8'h60, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_word(OP_READ,   ADDR_MSR,    8'h00, 1'b0, 8'h00, 1'b1,
              {8'hb0, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_word(OP_READ,   ADDR_UNUSED, 8'hff, 1'b1, 8'hff, 1'b1, QUIET);
    plan_word(OP_READ,   ADDR_DATA,   8'h00, 1'b0, 8'hff, 1'b1, QUIET);
    // divisor latch access with DLAB set
    plan_word(OP_WRITE,  ADDR_LCR,    8'hff, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_WRITE,  ADDR_DATA,   8'hff, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_WRITE,  ADDR_IER,    8'h00, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_READ,   ADDR_DATA,   8'h00, 1'b1, 8'h00, 1'b1,
              {8'hff, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_word(OP_READ,   ADDR_IER,    8'h00, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_READ,   ADDR_LCR,    8'h00, 1'b0, 8'h00, 1'b1,
              {8'hff, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_word(OP_WRITE,  ADDR_LCR,    8'h00, 1'b0, 8'h00, 1'b1, QUIET);
    // transmit with interrupts disabled, then writes to read-only offsets
    plan_word(OP_WRITE,  ADDR_DATA,   8'h00, 1'b0, 8'h00, 1'b1,
              {8'h00, 1'b1, 8'h00, 1'b0, 1'b0});
    plan_word(OP_WRITE,  ADDR_IIR,    8'hff, 1'b0, 8'h00, 1'b1, QUIET);
    plan_word(OP_WRITE,  ADDR_UNUSED, 8'hff, 1'b0, 8'h00, 1'b1, QUIET);
    // disabled THRE dropped by update, then the receive and transmit sources
    plan_word(OP_UPDATE, ADDR_DATA,   8'h00, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_WRITE,  ADDR_IER,    8'h03, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_POLL,   ADDR_DATA,   8'h00, 1'b1, 8'h00, 1'b0, QUIET);
    plan_word(OP_READ,   ADDR_LSR,    8'h00, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_UPDATE, ADDR_DATA,   8'h00, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_READ,   ADDR_IIR,    8'h00, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_READ,   ADDR_DATA,   8'h00, 1'b0, 8'h5a, 1'b0, QUIET);
    plan_word(OP_WRITE,  ADDR_DATA,   8'h80, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_UPDATE, ADDR_DATA,   8'h00, 1'b0, 8'h00, 1'b0, QUIET);
    plan_word(OP_READ,   ADDR_IIR,    8'h00, 1'b0, 8'h00, 1'b0, QUIET);

    repeat (2) @(negedge clk);
    rst       <= 1'b0;
    send_gaps  = 1'b1;
    sink_gaps  = 1'b1;

    foreach (stim_plan[i]) drive_word(stim_plan[i].word, stim_plan[i].fixed,
                                      stim_plan[i].result);

    // random phases, each opened once the block has drained
    for (int phase = 0; phase < 6; phase++) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (expected_results.size() != 0);
      send_gaps = (phase < 5) && ($urandom_range(0, 2) != 0);
      sink_gaps = (phase < 5) && ($urandom_range(0, 2) != 0);
      repeat (phase < 5 ? 100 : 150) drive_word(random_bus_word(), 1'b0, QUIET);
    end
    in_valid <= 1'b0;

    // drain and let the result register settle
    for (spin = 0; spin < 2000 && expected_results.size() != 0; spin++) @(negedge clk);
    repeat (4) @(negedge clk);
    while (expected_results.size() != 0) begin
      flag_mismatch("missing word", expected_results.pop_front(), QUIET);
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
